FILE: hw/rtl/gchf_pkg.sv
// ----------------------------------------------------------------------------
// gchf_pkg
// shared types and constants for the gyro / compass heading fusion core
// ----------------------------------------------------------------------------
package gchf_pkg;

    localparam int unsigned RateScaleQ16 = 149498;
    localparam int unsigned StepScaleQ40 = 781875;
    localparam int unsigned DtMaxUs      = 100000;
    localparam int unsigned DtDefaultUs  = 10;
    localparam int unsigned AtanEntries  = 24;

    // configuration register indexes
    localparam logic [2:0] REG_GYRO_BIAS   = 3'd0;
    localparam logic [2:0] REG_MAG_X_OFF   = 3'd1;
    localparam logic [2:0] REG_MAG_Y_OFF   = 3'd2;
    localparam logic [2:0] REG_MAG_X_SCALE = 3'd3;
    localparam logic [2:0] REG_MAG_Y_SCALE = 3'd4;
    localparam logic [2:0] REG_BLEND_GAIN  = 3'd5;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_PREP   = 3'd2,
        OP_STEP   = 3'd3,
        OP_CORDIC = 3'd4,
        OP_BLEND  = 3'd5,
        OP_FINISH = 3'd6
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] iter;
    } dp_cmd_t;

    // binary arctangent table, 2^32 per turn
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10679838;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/gchf_ctrl.sv
// ----------------------------------------------------------------------------
// gchf_ctrl
// sequencer: load, prepare, step products, cordic iterations, blend, output
// ----------------------------------------------------------------------------
module gchf_ctrl #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic               out_busy,
    output logic               s_ready,
    output gchf_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_STEP   = 3'd2;
    localparam logic [2:0] ST_CORDIC = 3'd3;
    localparam logic [2:0] ST_BLEND  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;
    localparam logic [4:0] LastIter  = 5'(CORDIC_STEPS - 1);

    logic [2:0] state_reg, state_next;
    logic [4:0] iter_reg, iter_next;

    assign s_ready = (state_reg == ST_IDLE);

    // state sequencing
    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd.op     = gchf_pkg::OP_NONE;
        cmd.iter   = iter_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.op     = gchf_pkg::OP_LOAD;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.op     = gchf_pkg::OP_PREP;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.op     = gchf_pkg::OP_STEP;
                iter_next  = 5'd0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.op    = gchf_pkg::OP_CORDIC;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == LastIter) state_next = ST_BLEND;
            end
            // blend writes the result register, so it waits for a held result
            ST_BLEND: begin
                if (!out_busy) begin
                    cmd.op     = gchf_pkg::OP_BLEND;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.op     = gchf_pkg::OP_FINISH;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= 5'd0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

FILE: hw/rtl/gchf_dp.sv
// ----------------------------------------------------------------------------
// gchf_dp
// datapath: rate scaling, mag correction, cordic, integration and blend
// ----------------------------------------------------------------------------
module gchf_dp #(
    parameter int unsigned ANGLE_FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  gchf_pkg::dp_cmd_t        cmd,
    input  logic signed [15:0]       gyro_z_raw,
    input  logic signed [15:0]       mag_x_raw,
    input  logic signed [15:0]       mag_y_raw,
    input  logic [19:0]              elapsed_us,
    input  logic                     actuator_on,
    input  logic signed [17:0]       gyro_bias,
    input  logic signed [15:0]       x_hard_off,
    input  logic signed [15:0]       y_hard_off,
    input  logic [15:0]              mag_x_scale,
    input  logic [15:0]              mag_y_scale,
    input  logic [15:0]              blend_gain,
    output logic signed [17:0]       rate_q,
    output logic [15:0]              gyro_q,
    output logic [15:0]              compass_q,
    output logic [15:0]              fused_q
);

    localparam int unsigned LowZero  = 16 - ANGLE_FRAC_BITS;
    localparam int unsigned StepSh   = 40 - ANGLE_FRAC_BITS;
    localparam logic [31:0] AngMask  = ~((32'd1 << LowZero) - 32'd1);

    // captured item
    logic signed [15:0] graw_reg, mx_reg, my_reg;
    logic [16:0] dt_reg;
    logic        act_reg;
    // intermediates
    logic signed [17:0] rate_reg;
    logic signed [35:0] rdt_reg;
    logic signed [41:0] xw_reg, yw_reg;
    logic [31:0] ang_reg, gyro_acc_reg, fused_acc_reg, step_reg;
    logic [31:0] gyro_acc_next, fused_acc_next;

    // rate scaling and saturation
    logic signed [33:0] scaled_prod;
    logic signed [17:0] scaled;
    logic signed [19:0] rate_diff;
    logic signed [17:0] rate_sat;
    assign scaled_prod = graw_reg * $signed({1'b0, 18'(gchf_pkg::RateScaleQ16)});
    assign scaled    = 18'((scaled_prod + 34'sd32768) >>> 16);
    assign rate_diff = 20'(gyro_bias) - 20'(scaled);
    always_comb begin
        if (rate_diff > 20'sd131071)       rate_sat = 18'sd131071;
        else if (rate_diff < -20'sd131072) rate_sat = -18'sd131072;
        else                               rate_sat = 18'(rate_diff);
    end

    // hard and soft iron correction
    logic signed [16:0] dx, dy;
    logic signed [34:0] px, py;
    logic signed [21:0] cx, cy;
    assign dx = 17'(mx_reg) - 17'(x_hard_off);
    assign dy = 17'(my_reg) - 17'(y_hard_off);
    assign px = dx * $signed({1'b0, mag_x_scale});
    assign py = dy * $signed({1'b0, mag_y_scale});
    assign cx = 22'((px + 35'sd8192) >>> 14);
    assign cy = 22'((py + 35'sd8192) >>> 14);

    // angle step: rate*dt then scale, rounded to the angle grid
    logic signed [56:0] step_prod;
    logic signed [56:0] step_units;
    assign step_prod  = 57'(rdt_reg) * 57'sd781875;
    assign step_units = (step_prod + (57'sd1 <<< (StepSh - 1))) >>> StepSh;

    // cordic vectoring step
    logic signed [41:0] xs, ys;
    logic [31:0] atan_v;
    assign xs     = xw_reg >>> cmd.iter;
    assign ys     = yw_reg >>> cmd.iter;
    assign atan_v = gchf_pkg::atan_entry(cmd.iter);

    // blend error and gain
    logic [31:0] fused_pre, compass_m, diff;
    logic signed [48:0] bprod;
    logic signed [48:0] bunits;
    assign fused_pre = (fused_acc_reg + step_reg) & AngMask;
    assign compass_m = ang_reg & AngMask;
    assign diff      = compass_m - fused_pre;
    assign bprod     = 49'($signed(diff)) * $signed({33'd0, blend_gain});
    assign bunits    = (bprod + (49'sd1 <<< (15 + LowZero))) >>> (16 + LowZero);

    always_comb begin
        gyro_acc_next  = gyro_acc_reg;
        fused_acc_next = fused_acc_reg;
        if (cmd.op == gchf_pkg::OP_BLEND) begin
            gyro_acc_next = (gyro_acc_reg + step_reg) & AngMask;
            if (act_reg) fused_acc_next = (gyro_acc_reg + step_reg) & AngMask;
            else fused_acc_next = (fused_pre + (32'(bunits) << LowZero)) & AngMask;
        end
    end

    // accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_acc_reg  <= 32'h8000_0000 & AngMask;
            fused_acc_reg <= 32'd0;
        end else begin
            gyro_acc_reg  <= gyro_acc_next;
            fused_acc_reg <= fused_acc_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            gchf_pkg::OP_LOAD: begin
                graw_reg <= gyro_z_raw;
                mx_reg   <= mag_x_raw;
                my_reg   <= mag_y_raw;
                act_reg  <= actuator_on;
                if (elapsed_us == 20'd0 || elapsed_us > 20'(gchf_pkg::DtMaxUs))
                    dt_reg <= 17'(gchf_pkg::DtDefaultUs);
                else
                    dt_reg <= 17'(elapsed_us);
            end
            gchf_pkg::OP_PREP: begin
                rate_reg <= rate_sat;
                if (cx == 0 && cy == 0) begin
                    xw_reg  <= 42'sd0;
                    yw_reg  <= 42'sd0;
                    ang_reg <= 32'd0;
                end else if (cx < 0) begin
                    xw_reg  <= -(42'(cx) <<< 10);
                    yw_reg  <= -(42'(cy) <<< 10);
                    ang_reg <= 32'h8000_0000;
                end else begin
                    xw_reg  <= 42'(cx) <<< 10;
                    yw_reg  <= 42'(cy) <<< 10;
                    ang_reg <= 32'd0;
                end
            end
            gchf_pkg::OP_STEP: begin
                rdt_reg <= rate_reg * $signed({1'b0, dt_reg});
            end
            gchf_pkg::OP_CORDIC: begin
                step_reg <= 32'(step_units) << LowZero;
                if (xw_reg == 0 && yw_reg == 0) begin
                    ang_reg <= 32'd0;
                end else if (yw_reg >= 0) begin
                    xw_reg  <= xw_reg + ys;
                    yw_reg  <= yw_reg - xs;
                    ang_reg <= ang_reg + atan_v;
                end else begin
                    xw_reg  <= xw_reg - ys;
                    yw_reg  <= yw_reg + xs;
                    ang_reg <= ang_reg - atan_v;
                end
            end
            gchf_pkg::OP_BLEND: begin
                rate_q    <= rate_reg;
                gyro_q    <= gyro_acc_next[31:16];
                compass_q <= compass_m[31:16];
                fused_q   <= fused_acc_next[31:16];
            end
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/gyro_compass_heading_fusion_core.sv
// ----------------------------------------------------------------------------
// gyro_compass_heading_fusion_core
// accepts a new item only when idle, so one item is in flight at a time; the
// shared cordic stage is iterated once per step; a held result stalls only
// the blend step
// reset: synchronous active low; gyro heading 180 deg, fused heading 0,
// registers to their defaults
// ----------------------------------------------------------------------------
module gyro_compass_heading_fusion_core #(
    parameter int unsigned CORDIC_STEPS    = 16,
    parameter int unsigned ANGLE_FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [17:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_gyro_z_raw,
    input  logic signed [15:0] s_mag_x_raw,
    input  logic signed [15:0] s_mag_y_raw,
    input  logic [19:0]        s_elapsed_us,
    input  logic               s_actuator_on,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [17:0] m_rate_out,
    output logic [15:0]        m_gyro_angle,
    output logic [15:0]        m_compass_angle,
    output logic [15:0]        m_fused_angle
);

    logic signed [17:0] gyro_bias_reg;
    logic signed [15:0] x_hard_off_reg, y_hard_off_reg;
    logic [15:0] mag_x_scale_reg, mag_y_scale_reg, blend_gain_reg;
    gchf_pkg::dp_cmd_t cmd;
    logic in_fire;
    logic m_valid_reg;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;
    assign m_valid   = m_valid_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_bias_reg   <= 18'sd0;
            x_hard_off_reg  <= 16'sd0;
            y_hard_off_reg  <= 16'sd0;
            mag_x_scale_reg <= 16'd16384;
            mag_y_scale_reg <= 16'd16384;
            blend_gain_reg  <= 16'd1311;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gchf_pkg::REG_GYRO_BIAS:   gyro_bias_reg   <= cfg_data;
                gchf_pkg::REG_MAG_X_OFF:   x_hard_off_reg  <= cfg_data[15:0];
                gchf_pkg::REG_MAG_Y_OFF:   y_hard_off_reg  <= cfg_data[15:0];
                gchf_pkg::REG_MAG_X_SCALE: mag_x_scale_reg <= cfg_data[15:0];
                gchf_pkg::REG_MAG_Y_SCALE: mag_y_scale_reg <= cfg_data[15:0];
                gchf_pkg::REG_BLEND_GAIN:  blend_gain_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    gchf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_busy (m_valid_reg && !m_ready),
        .s_ready  (s_ready),
        .cmd      (cmd)
    );

    gchf_dp #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .gyro_z_raw   (s_gyro_z_raw),
        .mag_x_raw    (s_mag_x_raw),
        .mag_y_raw    (s_mag_y_raw),
        .elapsed_us   (s_elapsed_us),
        .actuator_on  (s_actuator_on),
        .gyro_bias    (gyro_bias_reg),
        .x_hard_off   (x_hard_off_reg),
        .y_hard_off   (y_hard_off_reg),
        .mag_x_scale  (mag_x_scale_reg),
        .mag_y_scale  (mag_y_scale_reg),
        .blend_gain   (blend_gain_reg),
        .rate_q       (m_rate_out),
        .gyro_q       (m_gyro_angle),
        .compass_q    (m_compass_angle),
        .fused_q      (m_fused_angle)
    );

    // result transaction valid
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (cmd.op == gchf_pkg::OP_BLEND) m_valid_reg <= 1'b1;
        else if (m_ready) m_valid_reg <= 1'b0;
    end

    // no new transaction accepted while working on one
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("input accepted while busy");

    // result appears only after a blend step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.op == gchf_pkg::OP_BLEND))
        else $error("result without blend");

    // held fused angle is stable until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_fused_angle))
        else $error("result changed while stalled");

endmodule

FILE: dv/gyro_compass_heading_fusion_core_tb.sv
// ----------------------------------------------------------------------------
// gyro_compass_heading_fusion_core_tb
// self-checking bench: directed table plus random sensor transactions, each
// result compared against a local heading predictor, with bursty input
// traffic, output stalls and register changes between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gyro_compass_heading_fusion_core_tb;

    localparam int LATENCY     = 19;
    localparam int CYCLE_LIMIT = 400000;
    // index with no register behind it
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic signed [15:0] gyro;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic [19:0]        dt;
        logic               act;
    } sample_t;

    typedef struct packed {
        logic signed [17:0] rate;
        logic [15:0]        gyro_ang;
        logic [15:0]        comp_ang;
        logic [15:0]        fused_ang;
    } heading_t;

    // directed row: sample, whether a typed result applies, typed result
    typedef struct packed {
        sample_t  smp;
        logic     typed;
        heading_t res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [17:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_gyro_z_raw = '0;
    logic signed [15:0] s_mag_x_raw = '0;
    logic signed [15:0] s_mag_y_raw = '0;
    logic [19:0] s_elapsed_us = '0;
    logic s_actuator_on = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [17:0] m_rate_out;
    logic [15:0] m_gyro_angle;
    logic [15:0] m_compass_angle;
    logic [15:0] m_fused_angle;

    gyro_compass_heading_fusion_core DUT (.*);

    always #4 aclk = ~aclk;

    // predictor copy of registers and state
    longint bias_r, xoff_r, yoff_r, xscl_r, yscl_r, gain_r;
    logic [31:0] gyro_acc, fused_acc;
    heading_t pending_headings[$];
    int errors = 0;
    int cycles = 0;
    bit stall_on = 1'b0;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] compass_atan2(longint y, longint x);
        logic [31:0] ang;
        longint xs, ys;
        ang = 32'd0;
        if (x == 0 && y == 0) return 32'd0;
        x = x * 1024;
        y = y * 1024;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++) begin
            xs = floor_sh(x, i);
            ys = floor_sh(y, i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                ang = ang + gchf_pkg::atan_entry(5'(i));
            end else begin
                x = x - ys;
                y = y + xs;
                ang = ang - gchf_pkg::atan_entry(5'(i));
            end
        end
        return ang;
    endfunction

    function automatic heading_t predict_heading(sample_t s);
        heading_t h;
        longint scaled, rate, dt, cx, cy, err;
        logic [31:0] step, comp, d;
        scaled = round_sh(longint'(s.gyro) * gchf_pkg::RateScaleQ16, 16);
        rate = bias_r - scaled;
        if (rate > 131071) rate = 131071;
        if (rate < -131072) rate = -131072;
        dt = s.dt;
        if (dt == 0 || dt > gchf_pkg::DtMaxUs) dt = gchf_pkg::DtDefaultUs;
        step = 32'(round_sh(rate * dt * gchf_pkg::StepScaleQ40, 24));
        gyro_acc = gyro_acc + step;
        cx = round_sh((longint'(s.mx) - xoff_r) * xscl_r, 14);
        cy = round_sh((longint'(s.my) - yoff_r) * yscl_r, 14);
        comp = compass_atan2(cy, cx);
        if (s.act) begin
            fused_acc = gyro_acc;
        end else begin
            fused_acc = fused_acc + step;
            d = comp - fused_acc;
            err = longint'($signed(d));
            fused_acc = fused_acc + 32'(round_sh(err * gain_r, 16));
        end
        h.rate = 18'(rate);
        h.gyro_ang = gyro_acc[31:16];
        h.comp_ang = comp[31:16];
        h.fused_ang = fused_acc[31:16];
        return h;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [17:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            gchf_pkg::REG_GYRO_BIAS:   bias_r = longint'($signed(val));
            gchf_pkg::REG_MAG_X_OFF:   xoff_r = longint'($signed(val[15:0]));
            gchf_pkg::REG_MAG_Y_OFF:   yoff_r = longint'($signed(val[15:0]));
            gchf_pkg::REG_MAG_X_SCALE: xscl_r = val[15:0];
            gchf_pkg::REG_MAG_Y_SCALE: yscl_r = val[15:0];
            gchf_pkg::REG_BLEND_GAIN:  gain_r = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain_results();
        while (pending_headings.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // send one transaction; typed rows are checked against the typed result
    task automatic send_sample(sample_t s, logic typed, heading_t want);
        heading_t h;
        h = predict_heading(s);
        if (typed && h != want)
            $error("typed row mismatch: expected %h predicted %h", want, h);
        s_valid <= 1'b1;
        s_gyro_z_raw <= s.gyro;
        s_mag_x_raw <= s.mx;
        s_mag_y_raw <= s.my;
        s_elapsed_us <= s.dt;
        s_actuator_on <= s.act;
        do @(posedge aclk); while (!s_ready);
        if (typed) pending_headings.push_back(want);
        else pending_headings.push_back(h);
    endtask

    task automatic idle_gap();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge aclk);
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        s.gyro = 16'($urandom);
        if ($urandom_range(0, 3) != 0) s.gyro = 16'($signed(16'($urandom_range(0, 4000))) - 2000);
        s.mx = 16'($urandom);
        s.my = 16'($urandom);
        case ($urandom_range(0, 7))
            0: s.dt = 20'($urandom);
            1: s.dt = 20'd0;
            2: s.dt = 20'd100000 + 20'($urandom_range(0, 2));
            default: s.dt = 20'($urandom_range(1, 2000));
        endcase
        s.act = ($urandom_range(0, 4) == 0);
        return s;
    endfunction

    // output stall pattern and checker
    always @(posedge aclk) begin
        heading_t want;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_headings.size() == 0) begin
                $error("result with no expectation waiting");
                errors = errors + 1;
            end else begin
                want = pending_headings.pop_front();
                if (m_rate_out !== want.rate) begin
                    $error("rate_out expected %0d actual %0d", want.rate, m_rate_out);
                    errors = errors + 1;
                end
                if (m_gyro_angle !== want.gyro_ang) begin
                    $error("gyro_angle expected %0d actual %0d", want.gyro_ang, m_gyro_angle);
                    errors = errors + 1;
                end
                if (m_compass_angle !== want.comp_ang) begin
                    $error("compass_angle expected %0d actual %0d",
                           want.comp_ang, m_compass_angle);
                    errors = errors + 1;
                end
                if (m_fused_angle !== want.fused_ang) begin
                    $error("fused_angle expected %0d actual %0d",
                           want.fused_ang, m_fused_angle);
                    errors = errors + 1;
                end
            end
        end
        if (stall_on) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= 1'b1;
        if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("** gyro_compass_heading_fusion_core: FAILED **");
            $finish;
        end
    end

    row_t dir_rows[$];
    heading_t zero_res;

    initial begin
        sample_t s;
        int burst;
        bias_r = 0; xoff_r = 0; yoff_r = 0;
        xscl_r = 16384; yscl_r = 16384; gain_r = 1311;
        gyro_acc = 32'h8000_0000;
        fused_acc = 32'd0;
        zero_res = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first row after reset, zero field, no rate
        dir_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 20'd0, 1'b0}, 1'b1,
                             '{18'sd0, 16'h8000, 16'h0000, 16'h0000}});
        // extremes of the fields, dt out of range, solenoid on
        dir_rows.push_back('{'{16'sh7fff, 16'sh7fff, 16'sd0, 20'd100000, 1'b0}, 1'b0, zero_res});
        dir_rows.push_back('{'{16'sh8000, 16'sh8000, 16'sd0, 20'd100001, 1'b0}, 1'b0, zero_res});
        dir_rows.push_back('{'{16'sh7fff, 16'sd0, 16'sh7fff, 20'hfffff, 1'b1}, 1'b0, zero_res});
        dir_rows.push_back('{'{16'sh8000, 16'sd0, 16'sh8000, 20'd1, 1'b1}, 1'b0, zero_res});
        dir_rows.push_back('{'{16'sd1, 16'shffff, 16'shffff, 20'd99999, 1'b0}, 1'b0, zero_res});
        dir_rows.push_back('{'{16'shffff, 16'sh8000, 16'sh7fff, 20'd1000, 1'b0}, 1'b0, zero_res});
        dir_rows.push_back('{'{16'sd0, 16'sh8000, 16'sh8000, 20'd1, 1'b0}, 1'b0, zero_res});
        dir_rows.push_back('{'{16'sd100, 16'sd0, 16'sd0, 20'd50000, 1'b0}, 1'b0, zero_res});
        dir_rows.push_back('{'{16'sh5555, 16'shaaaa, 16'sh5555, 20'haaaaa, 1'b1}, 1'b0, zero_res});
        dir_rows.push_back('{'{16'shaaaa, 16'sh5555, 16'shaaaa, 20'h55555, 1'b0}, 1'b0, zero_res});
        foreach (dir_rows[i]) send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].res);
        s_valid <= 1'b0;
        drain_results();

        // rate saturation with extreme bias, and full gain (opposite heading)
        write_reg(gchf_pkg::REG_GYRO_BIAS, 18'h1ffff);
        write_reg(gchf_pkg::REG_BLEND_GAIN, 18'hffff);
        send_sample('{16'sh8000, -16'sd100, 16'sd0, 20'd100000, 1'b0}, 1'b0, zero_res);
        send_sample('{16'sd0, 16'sd100, 16'sd0, 20'd10, 1'b0}, 1'b0, zero_res);
        send_sample('{16'sd0, -16'sd100, 16'sd0, 20'd10, 1'b0}, 1'b0, zero_res);
        s_valid <= 1'b0;
        drain_results();
        write_reg(gchf_pkg::REG_GYRO_BIAS, 18'h20000);
        write_reg(gchf_pkg::REG_MAG_X_OFF, 18'h07fff);
        write_reg(gchf_pkg::REG_MAG_Y_OFF, 18'h08000);
        write_reg(gchf_pkg::REG_MAG_X_SCALE, 18'hffff);
        write_reg(gchf_pkg::REG_MAG_Y_SCALE, 18'h0000);
        write_reg(gchf_pkg::REG_BLEND_GAIN, 18'h0000);
        write_reg(REG_UNMAPPED, 18'h3ffff);
        send_sample('{16'sh7fff, 16'sh8000, 16'sh7fff, 20'd100000, 1'b0}, 1'b0, zero_res);
        send_sample('{16'sh7fff, 16'sh7fff, 16'sh8000, 20'd0, 1'b0}, 1'b0, zero_res);
        s_valid <= 1'b0;
        drain_results();

        // random phases, each with its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(gchf_pkg::REG_GYRO_BIAS, 18'($urandom));
            write_reg(gchf_pkg::REG_MAG_X_OFF, 18'($urandom_range(0, 2000)) - 18'd1000);
            write_reg(gchf_pkg::REG_MAG_Y_OFF, 18'($urandom));
            write_reg(gchf_pkg::REG_MAG_X_SCALE,
                      (ph == 5) ? 18'h0000 : 18'($urandom_range(8000, 40000)));
            write_reg(gchf_pkg::REG_MAG_Y_SCALE, (ph == 4) ? 18'hffff : 18'($urandom));
            write_reg(gchf_pkg::REG_BLEND_GAIN, (ph == 0) ? 18'h0051f : 18'($urandom));
            burst = 0;
            for (int n = 0; n < 100; n++) begin
                if (burst == 0) begin
                    if ($urandom_range(0, 1)) idle_gap();
                    burst = $urandom_range(1, 20);
                end
                s = random_sample();
                send_sample(s, 1'b0, zero_res);
                burst = burst - 1;
            end
            s_valid <= 1'b0;
            drain_results();
        end

        if (errors == 0)
            $display("** gyro_compass_heading_fusion_core: PASSED **");
        else
            $display("** gyro_compass_heading_fusion_core: FAILED **");
        $finish;
    end

endmodule

FILE: gyro_compass_heading_fusion_core.f
hw/rtl/gchf_pkg.sv
hw/rtl/gchf_ctrl.sv
hw/rtl/gchf_dp.sv
hw/rtl/gyro_compass_heading_fusion_core.sv
dv/gyro_compass_heading_fusion_core_tb.sv
